// ----- design/csm_pkg.sv -----
// csm_pkg: shared types and constants for the CIGAR block merger.
// Holds the input and result transaction structs and the operation codes.
// No dependencies.
package csm_pkg;

    // Item kinds
    localparam logic MODE_BEGIN = 1'b0;
    localparam logic MODE_OP    = 1'b1;

    // CIGAR operation characters (ASCII)
    localparam logic [7:0] OP_MATCH    = 8'h4D;  // 'M'
    localparam logic [7:0] OP_SEQ_EQ   = 8'h3D;  // '='
    localparam logic [7:0] OP_SEQ_DIFF = 8'h58;  // 'X'
    localparam logic [7:0] OP_DEL      = 8'h44;  // 'D'
    localparam logic [7:0] OP_SKIP     = 8'h4E;  // 'N'
    localparam logic [7:0] OP_INS      = 8'h49;  // 'I'
    localparam logic [7:0] OP_PAD      = 8'h50;  // 'P'

    localparam logic [15:0] MERGE_GAP_RESET = 16'd10;

    typedef struct packed {
        logic        mode;
        logic        reverse_strand;
        logic [30:0] record_query_start;
        logic [30:0] record_query_end;
        logic [30:0] record_template_start;
        logic [7:0]  op_code;
        logic [27:0] op_length;
        logic        last_op;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] block_query_start;
        logic signed [31:0] block_query_end;
        logic signed [31:0] block_template_start;
        logic signed [31:0] block_template_end;
        logic               block_reverse;
        logic               last_block;
    } out_item_t;

    // Results produced by one step: first slot, then second slot
    typedef struct packed {
        logic first;
        logic second;
    } csm_push_t;

endpackage

// ----- design/cigar_segment_merger.sv -----
// cigar_segment_merger: CIGAR operations in, merged matched blocks out. Depends on
// csm_pkg, csm_step, csm_out_fifo. An accepted input transaction waits in the input
// register, then its results go into the result queue. Throughput: one input
// transaction per cycle while the result queue has room for two results; a slow
// consumer sets the long-run rate when records emit many blocks. Asynchronous
// active-low reset clears cursors, pending block and queue; merge gap limit goes to 10.
module cigar_segment_merger
    import csm_pkg::*;
#(
    parameter int OUT_DEPTH = 4   // result queue entries, at least 2
)
(
    input  logic        clk,
    input  logic        rst_n,

    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,

    // merge gap limit register
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    // ------------------------------------------------------------------
    // Configuration: merge gap limit, zero disables merging
    // ------------------------------------------------------------------
    logic [15:0] gap_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_limit_reg <= MERGE_GAP_RESET;
        else if (cfg_wr_en)
            gap_limit_reg <= cfg_wr_data;
    end

    // ------------------------------------------------------------------
    // Input register. It is processed in the next cycle whenever the
    // result queue can absorb a worst-case step (two results).
    // ------------------------------------------------------------------
    logic      in_vld_reg, in_vld_next;
    in_item_t  in_item_reg;
    logic      room2;
    logic      proc_fire;
    logic      in_accept;
    logic      pop;
    logic      nonempty;
    csm_push_t push;
    out_item_t res0, res1;

    assign proc_fire = in_vld_reg && room2;
    // stall only when the held transaction cannot move on this cycle
    assign in_stall  = in_vld_reg && !room2;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept)
            in_vld_next = 1'b1;
        else if (proc_fire)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_item_reg <= in_item;
    end

    // ------------------------------------------------------------------
    // Step logic: cursors, pending block, merge decision
    // ------------------------------------------------------------------
    csm_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc_fire),
        .item      (in_item_reg),
        .gap_limit (gap_limit_reg),
        .push      (push),
        .res0      (res0),
        .res1      (res1)
    );

    // ------------------------------------------------------------------
    // Result queue; it decouples the output stall from the input side
    // ------------------------------------------------------------------
    assign pop       = nonempty && !out_stall;
    assign out_valid = nonempty;

    csm_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res0     (res0),
        .res1     (res1),
        .pop      (pop),
        .room2    (room2),
        .nonempty (nonempty),
        .head     (out_item)
    );

endmodule

// ----- design/csm_step.sv -----
// csm_step: cursor and pending-block state plus the per-operation update.
// Emits up to two result transactions per processed item.
// Depends on csm_pkg.
module csm_step
    import csm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  in_item_t    item,
    input  logic [15:0] gap_limit,
    output csm_push_t   push,
    output out_item_t   res0,
    output out_item_t   res1
);

    logic        rev_reg, rev_next;
    logic [31:0] qcur_reg, qcur_next;
    logic [31:0] tcur_reg, tcur_next;
    logic [31:0] pq_lo_reg, pq_lo_next;
    logic [31:0] pq_hi_reg, pq_hi_next;
    logic [31:0] pt_lo_reg, pt_lo_next;
    logic [31:0] pt_hi_reg, pt_hi_next;
    logic        pv_reg, pv_next;

    logic [31:0] len32;
    logic [31:0] qlo, qhi, tlo, thi;
    logic [31:0] gap;
    logic        is_match, is_tadv, is_qadv;
    logic        merge;

    assign len32    = {4'd0, item.op_length};
    assign is_match = (item.op_code == OP_MATCH) || (item.op_code == OP_SEQ_EQ)
                   || (item.op_code == OP_SEQ_DIFF);
    assign is_tadv  = (item.op_code == OP_DEL) || (item.op_code == OP_SKIP);
    assign is_qadv  = (item.op_code == OP_INS) || (item.op_code == OP_PAD);

    assign tlo = tcur_reg;
    assign thi = tcur_reg + len32 - 32'd1;
    assign qlo = rev_reg ? (qcur_reg - len32) : qcur_reg;
    assign qhi = rev_reg ? (qcur_reg - 32'd1) : (qcur_reg + len32 - 32'd1);

    // signed gap from the pending inclusive end, against the unsigned limit
    assign gap   = tlo - pt_hi_reg;
    assign merge = pv_reg && (gap_limit != 16'd0)
                && ($signed({gap[31], gap}) < $signed({17'd0, gap_limit}));

    always_comb
    begin
        rev_next   = rev_reg;
        qcur_next  = qcur_reg;
        tcur_next  = tcur_reg;
        pq_lo_next = pq_lo_reg;
        pq_hi_next = pq_hi_reg;
        pt_lo_next = pt_lo_reg;
        pt_hi_next = pt_hi_reg;
        pv_next    = pv_reg;
        push       = '0;
        res0       = '0;
        res1       = '0;

        if (fire)
        begin
            if (item.mode == MODE_BEGIN)
            begin
                rev_next  = item.reverse_strand;
                tcur_next = {1'b0, item.record_template_start};
                qcur_next = item.reverse_strand ? ({1'b0, item.record_query_end} - 32'd1)
                                                : {1'b0, item.record_query_start};
                pv_next   = 1'b0;
            end
            else
            begin
                if (is_match)
                begin
                    qcur_next = rev_reg ? qlo : (qcur_reg + len32);
                    tcur_next = tcur_reg + len32;
                    if (merge)
                    begin
                        if (rev_reg)
                            pq_lo_next = qlo;
                        else
                            pq_hi_next = qhi;
                        pt_hi_next = thi;
                    end
                    else
                    begin
                        // close the previous block
                        push.first = pv_reg;
                        res0 = '{block_query_start:    pq_lo_reg,
                                 block_query_end:      pq_hi_reg,
                                 block_template_start: pt_lo_reg,
                                 block_template_end:   pt_hi_reg,
                                 block_reverse:        rev_reg,
                                 last_block:           1'b0};
                        pq_lo_next = qlo;
                        pq_hi_next = qhi;
                        pt_lo_next = tlo;
                        pt_hi_next = thi;
                        pv_next    = 1'b1;
                    end
                end
                else if (is_tadv)
                begin
                    tcur_next = tcur_reg + len32;
                end
                else if (is_qadv)
                begin
                    qcur_next = rev_reg ? (qcur_reg - len32) : (qcur_reg + len32);
                end

                // flush on the final operation
                if (item.last_op && pv_next)
                begin
                    if (push.first)
                    begin
                        push.second = 1'b1;
                        res1 = '{block_query_start:    pq_lo_next,
                                 block_query_end:      pq_hi_next,
                                 block_template_start: pt_lo_next,
                                 block_template_end:   pt_hi_next,
                                 block_reverse:        rev_reg,
                                 last_block:           1'b1};
                    end
                    else
                    begin
                        push.first = 1'b1;
                        res0 = '{block_query_start:    pq_lo_next,
                                 block_query_end:      pq_hi_next,
                                 block_template_start: pt_lo_next,
                                 block_template_end:   pt_hi_next,
                                 block_reverse:        rev_reg,
                                 last_block:           1'b1};
                    end
                    pv_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_reg   <= 1'b0;
            qcur_reg  <= '0;
            tcur_reg  <= '0;
            pq_lo_reg <= '0;
            pq_hi_reg <= '0;
            pt_lo_reg <= '0;
            pt_hi_reg <= '0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            rev_reg   <= rev_next;
            qcur_reg  <= qcur_next;
            tcur_reg  <= tcur_next;
            pq_lo_reg <= pq_lo_next;
            pq_hi_reg <= pq_hi_next;
            pt_lo_reg <= pt_lo_next;
            pt_hi_reg <= pt_hi_next;
            pv_reg    <= pv_next;
        end
    end

endmodule

// ----- design/csm_out_fifo.sv -----
// csm_out_fifo: small flop-based result queue, two writes and one read per cycle.
// Reports whether a full two-result step fits. Depends on csm_pkg.
module csm_out_fifo
    import csm_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  csm_push_t push,
    input  out_item_t res0,
    input  out_item_t res1,
    input  logic      pop,
    output logic      room2,
    output logic      nonempty,
    output out_item_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    out_item_t      mem_reg [DEPTH];
    logic [PW-1:0]  head_reg, head_next;
    logic [PW-1:0]  tail_reg, tail_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [PW-1:0]  tail_plus1;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : (p + PW'(1));
    endfunction

    assign tail_plus1 = ptr_inc(tail_reg);
    assign nonempty   = (count_reg != '0);
    assign head       = mem_reg[head_reg];
    assign room2      = (count_reg <= CW'(DEPTH - 2))
                     || ((count_reg == CW'(DEPTH - 1)) && pop);

    always_comb
    begin
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        tail_next  = push.second ? ptr_inc(tail_plus1)
                   : (push.first ? tail_plus1 : tail_reg);
        count_next = count_reg + CW'(push.first) + CW'(push.second) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
            mem_reg[tail_reg] <= res0;
        if (push.second)
            mem_reg[tail_plus1] <= res1;
    end

endmodule

// ----- design/csm_checker.sv -----
// csm_checker: port-level assertions for cigar_segment_merger, bound to the top.
// Depends on csm_pkg.
module csm_checker
    import csm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input out_item_t   out_item
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // input back-pressure only comes from queued results
    a_stall_needs_output: assert property (@(posedge clk)
        in_stall |-> out_valid)
        else $error("input stalled with nothing queued");

    // first result after empty comes from an accepted transaction that passed the input register
    a_rise_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without a source transaction");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind cigar_segment_merger csm_checker u_csm_checker (.*);

// ----- tb/sv/cigar_segment_merger_test.sv -----
// cigar_segment_merger_test: self-checking testbench for the CIGAR block merger.
// Streams begin/op transactions and checks every block against a built-in predictor.
// Depends on csm_pkg and cigar_segment_merger.
module cigar_segment_merger_test
    import csm_pkg::*;
;

    // Clip and stray codes: the block must ignore all of these
    localparam logic [7:0] OP_SOFT_CLIP = 8'h53;  // 'S'
    localparam logic [7:0] OP_HARD_CLIP = 8'h48;  // 'H'
    localparam logic [7:0] CODE_ZERO    = 8'h00;
    localparam logic [7:0] CODE_ONES    = 8'hFF;

    localparam int ITEMS_PER_PHASE = 205;
    localparam int SETTLE_CYCLES   = 8;     // drain margin after every owed block has come back
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transaction on either side
    localparam int REPORT_LIMIT    = 10;

    // Block predictor plus the queue of blocks still owed by the block.
    class block_scoreboard;
        logic [15:0] gap_limit;
        logic        rev;
        logic [31:0] q_cur, t_cur;
        logic [31:0] pq_lo, pq_hi, pt_lo, pt_hi;
        logic        pend;
        out_item_t   owed_blocks[$];
        int          failures;

        function new();
            gap_limit = MERGE_GAP_RESET;
            rev       = 1'b0;
            q_cur     = '0;
            t_cur     = '0;
            pq_lo     = '0;
            pq_hi     = '0;
            pt_lo     = '0;
            pt_hi     = '0;
            pend      = 1'b0;
            failures  = 0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        function void push_pending(logic final_blk);
            out_item_t blk;
            blk.block_query_start    = pq_lo;
            blk.block_query_end      = pq_hi;
            blk.block_template_start = pt_lo;
            blk.block_template_end   = pt_hi;
            blk.block_reverse        = rev;
            blk.last_block           = final_blk;
            owed_blocks = {owed_blocks, blk};
        endfunction

        // Advance the predictor by one accepted input transaction.
        function void note_input(in_item_t it);
            logic [31:0] len, q_lo, q_hi, t_lo, t_hi;
            int          gap;
            if (it.mode == MODE_BEGIN)
            begin
                // new record: strand and cursors latched, any pending block dropped
                rev   = it.reverse_strand;
                t_cur = {1'b0, it.record_template_start};
                q_cur = rev ? ({1'b0, it.record_query_end} - 32'd1)
                            : {1'b0, it.record_query_start};
                pend  = 1'b0;
                return;
            end
            len = {4'd0, it.op_length};
            if (it.op_code == OP_MATCH || it.op_code == OP_SEQ_EQ ||
                it.op_code == OP_SEQ_DIFF)
            begin
                t_lo = t_cur;
                t_hi = t_cur + len - 32'd1;
                if (rev)
                begin
                    q_lo  = q_cur - len;
                    q_hi  = q_cur - 32'd1;
                    q_cur = q_lo;
                end
                else
                begin
                    q_lo  = q_cur;
                    q_hi  = q_cur + len - 32'd1;
                    q_cur = q_cur + len;
                end
                t_cur = t_cur + len;
                // template gap is a wrapped difference seen as signed 32 bits
                gap = int'(t_lo - pt_hi);
                if (pend && gap_limit != 16'd0 && gap < int'(gap_limit))
                begin
                    if (rev)
                        pq_lo = q_lo;
                    else
                        pq_hi = q_hi;
                    pt_hi = t_hi;
                end
                else
                begin
                    if (pend)
                        push_pending(1'b0);
                    pq_lo = q_lo;
                    pq_hi = q_hi;
                    pt_lo = t_lo;
                    pt_hi = t_hi;
                    pend  = 1'b1;
                end
            end
            else if (it.op_code == OP_DEL || it.op_code == OP_SKIP)
            begin
                t_cur = t_cur + len;
            end
            else if (it.op_code == OP_INS || it.op_code == OP_PAD)
            begin
                q_cur = rev ? q_cur - len : q_cur + len;
            end
            if (it.last_op && pend)
            begin
                push_pending(1'b1);
                pend = 1'b0;
            end
        endfunction

        // Compare one accepted result against the oldest owed block.
        function void check_result(out_item_t got);
            out_item_t want;
            logic      bad;
            if (owed_blocks.size() == 0)
            begin
                note_failure($sformatf("unexpected block q %0d..%0d t %0d..%0d r%0b l%0b",
                    got.block_query_start, got.block_query_end, got.block_template_start,
                    got.block_template_end, got.block_reverse, got.last_block));
                return;
            end
            want = owed_blocks.pop_front();
            bad  = 1'b0;
            if (got.block_query_start    !== want.block_query_start)    bad = 1'b1;
            if (got.block_query_end      !== want.block_query_end)      bad = 1'b1;
            if (got.block_template_start !== want.block_template_start) bad = 1'b1;
            if (got.block_template_end   !== want.block_template_end)   bad = 1'b1;
            if (got.block_reverse        !== want.block_reverse)        bad = 1'b1;
            if (got.last_block           !== want.last_block)           bad = 1'b1;
            if (bad)
                note_failure($sformatf({"block mismatch: exp q %0d..%0d t %0d..%0d r%0b l%0b",
                    " / got q %0d..%0d t %0d..%0d r%0b l%0b"},
                    want.block_query_start, want.block_query_end, want.block_template_start,
                    want.block_template_end, want.block_reverse, want.last_block,
                    got.block_query_start, got.block_query_end, got.block_template_start,
                    got.block_template_end, got.block_reverse, got.last_block));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    block_scoreboard sb = new();
    int idle_cycles = 0;   // cycles since the last transaction on either channel
    int calm_left   = 0;   // sender stretch with no idling
    int items_sent  = 0;   // input transactions accepted in the current phase

    cigar_segment_merger u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: inputs are noted before outputs are checked, all in one process,
    // so prediction never races the result check.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: nothing moving for too long means a hang.
    initial
    begin
        do @(negedge clk); while (idle_cycles < WATCHDOG_LIMIT);
        $display("[cigar_segment_merger] ERROR");
        $finish;
    end

    // Result side back-pressure: calm stretches, short stalls, now and then a long one.
    initial
    begin
        int calm;
        int hold;
        out_stall = 1'b0;
        forever
        begin
            calm = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 6);
            repeat (calm) @(negedge clk) out_stall <= 1'b0;
            hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
            repeat (hold) @(negedge clk) out_stall <= 1'b1;
        end
    end

    // Sender idle cycles before the next transaction: mostly none or short.
    function automatic int pick_sender_gap();
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm_left = $urandom_range(30, 100);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Begin transaction; the op fields are don't-care and carry noise.
    function automatic in_item_t mk_begin(logic rev, logic [30:0] qs, logic [30:0] qe,
                                          logic [30:0] ts);
        in_item_t it;
        it.mode                  = MODE_BEGIN;
        it.reverse_strand        = rev;
        it.record_query_start    = qs;
        it.record_query_end      = qe;
        it.record_template_start = ts;
        it.op_code               = 8'($urandom);
        it.op_length             = 28'($urandom);
        it.last_op               = 1'($urandom);
        return it;
    endfunction

    // Operation transaction; the record fields are don't-care and carry noise.
    function automatic in_item_t mk_op(logic [7:0] code, logic [27:0] len, logic final_op);
        in_item_t it;
        it.mode                  = MODE_OP;
        it.reverse_strand        = 1'($urandom);
        it.record_query_start    = 31'($urandom);
        it.record_query_end      = 31'($urandom);
        it.record_template_start = 31'($urandom);
        it.op_code               = code;
        it.op_length             = len;
        it.last_op               = final_op;
        return it;
    endfunction

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Hold off the sender until every owed block has come back.
    task automatic wait_for_blocks();
        drop_valid();
        while (sb.owed_blocks.size() != 0)
            @(negedge clk);
    endtask

    // Quiet point for a register write: no blocks owed and nothing left in flight.
    task automatic drain_block();
        wait_for_blocks();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_gap_limit(input logic [15:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        sb.gap_limit = value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 16'($urandom);
    endtask

    // Drive one input transaction and wait for the handshake. Valid stays high
    // between back-to-back transactions.
    task automatic put_item(input in_item_t it);
        int idle;
        if ($urandom_range(0, 199) == 0)
            wait_for_blocks();
        idle = pick_sender_gap();
        @(negedge clk);
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    function automatic logic [30:0] pick_coord();
        if ($urandom_range(0, 3) == 0)
            return 31'($urandom);
        return 31'($urandom_range(0, 5000));
    endfunction

    function automatic logic [7:0] pick_op_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return OP_MATCH;
        if (roll < 38) return OP_SEQ_EQ;
        if (roll < 46) return OP_SEQ_DIFF;
        if (roll < 58) return OP_DEL;
        if (roll < 68) return OP_SKIP;
        if (roll < 80) return OP_INS;
        if (roll < 86) return OP_PAD;
        if (roll < 92) return OP_SOFT_CLIP;
        if (roll < 95) return OP_HARD_CLIP;
        return 8'($urandom);
    endfunction

    // Lengths: mostly short; template skips often land right at the merge threshold.
    function automatic logic [27:0] pick_op_length(logic [7:0] code);
        int roll;
        int near;
        roll = $urandom_range(0, 99);
        if (roll < 3) return 28'($urandom);
        if (roll < 4) return 28'hFFF_FFFF;
        if (roll < 6) return 28'd0;
        if ((code == OP_DEL || code == OP_SKIP) && roll < 45)
        begin
            near = int'(sb.gap_limit) + $urandom_range(0, 3) - 2;
            return (near < 0) ? 28'd0 : 28'(near);
        end
        return 28'($urandom_range(0, 40));
    endfunction

    // One record: mostly well formed; a few lack the begin, the final op, or end early.
    task automatic send_record();
        int         shape;
        int         n_ops;
        logic [7:0] code;
        logic       final_op;
        shape = $urandom_range(0, 99);
        if (shape >= 5)
            put_item(mk_begin(1'($urandom), pick_coord(), pick_coord(), pick_coord()));
        n_ops = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
        for (int i = 0; i < n_ops; i++)
        begin
            code     = pick_op_code();
            final_op = (i == n_ops - 1) && !(shape >= 5 && shape < 10);
            if (shape >= 10 && shape < 15 && $urandom_range(0, 3) == 0)
                final_op = 1'b1;
            put_item(mk_op(code, pick_op_length(code), final_op));
        end
    endtask

    // Directed: field extremes, every op, clips and stray codes, and the odd records:
    // no blocks at all, begin over a pending block, ops after the final one,
    // zero-length match, reverse strand with query end zero.
    task automatic run_directed();
        put_item(mk_begin(1'b0, 31'd0, 31'd100, 31'd0));
        put_item(mk_op(OP_MATCH, 28'd5, 1'b0));
        put_item(mk_op(OP_DEL, 28'd3, 1'b0));
        put_item(mk_op(OP_SEQ_EQ, 28'd4, 1'b0));         // gap 4, merges
        put_item(mk_op(OP_SKIP, 28'd20, 1'b0));
        put_item(mk_op(OP_SEQ_DIFF, 28'd2, 1'b0));       // gap 21, splits
        put_item(mk_op(OP_INS, 28'd7, 1'b0));
        put_item(mk_op(OP_PAD, 28'd1, 1'b0));
        put_item(mk_op(OP_SOFT_CLIP, 28'd5, 1'b0));
        put_item(mk_op(OP_HARD_CLIP, 28'hFFF_FFFF, 1'b0));
        put_item(mk_op(CODE_ZERO, 28'd9, 1'b0));
        put_item(mk_op(CODE_ONES, 28'd9, 1'b0));
        put_item(mk_op(OP_MATCH, 28'd0, 1'b1));          // zero-length block, flush
        put_item(mk_begin(1'b1, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF));
        put_item(mk_op(OP_MATCH, 28'hFFF_FFFF, 1'b0));
        put_item(mk_op(OP_INS, 28'd3, 1'b0));
        put_item(mk_op(OP_MATCH, 28'd1, 1'b1));
        put_item(mk_begin(1'b0, 31'd50, 31'h7FFF_FFFF, 31'd1000));
        put_item(mk_op(OP_DEL, 28'd5, 1'b0));
        put_item(mk_op(OP_SOFT_CLIP, 28'd1, 1'b1));      // record without blocks
        put_item(mk_begin(1'b1, 31'd10, 31'd60, 31'd200));
        put_item(mk_op(OP_MATCH, 28'd3, 1'b0));
        put_item(mk_begin(1'b0, 31'd0, 31'd40, 31'd300)); // drops the pending block
        put_item(mk_op(OP_MATCH, 28'd2, 1'b1));
        put_item(mk_op(OP_MATCH, 28'd4, 1'b1));          // continues after the final op
    endtask

    initial
    begin
        logic [15:0] limits[6];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part runs at the reset merge limit
        run_directed();
        drain_block();

        // merging off, tightest, widest, then a few in between
        limits[0] = 16'd0;
        limits[1] = 16'd1;
        limits[2] = 16'hFFFF;
        limits[3] = 16'd2;
        limits[4] = 16'($urandom_range(3, 40));
        limits[5] = 16'($urandom);
        foreach (limits[p])
        begin
            write_gap_limit(limits[p]);
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE)
                send_record();
            drain_block();
        end

        if (sb.failures == 0 && sb.owed_blocks.size() == 0)
            $display("[cigar_segment_merger] OK");
        else
            $display("[cigar_segment_merger] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/csm_pkg.sv
design/csm_step.sv
design/csm_out_fifo.sv
design/cigar_segment_merger.sv
design/csm_checker.sv
tb/sv/cigar_segment_merger_test.sv
